/* hdl/word_distance_unit_assert.svh */
// ----------------------------------------------------------------------------
// word_distance_unit_assert: assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef WORD_DISTANCE_UNIT_ASSERT_SVH
`define WORD_DISTANCE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define WDU_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("word_distance_unit: same-cycle check failed");
`define WDU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("word_distance_unit: next-cycle check failed");
`else
`define WDU_ASSERT_SAME(lbl, ante, cons)
`define WDU_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* hdl/wdu_pkg.sv */
// ----------------------------------------------------------------------------
// wdu_pkg
// Shared constants, codes and types of the word distance unit.
// ----------------------------------------------------------------------------
`default_nettype none

package wdu_pkg;

  localparam int MAX_WORD = 31;
  localparam int MIN_WORD = 4;
  localparam int LEN_W    = $clog2(MAX_WORD + 2);
  localparam int SLOT_W   = $clog2(MAX_WORD);
  localparam int CHAR_W   = 8;
  localparam int FUNC_W   = 2;

  localparam logic [FUNC_W-1:0] FUNC_EDIT    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_HAMMING = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_EXACT   = 2'd2;

  localparam logic [LEN_W-1:0] DIST_INVALID = '1;

  // Wavefront token handed from one cell to the next.
  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] chr;
    logic [LEN_W-1:0]  left;   // new value of the cell above
    logic [LEN_W-1:0]  diag;   // old value of the cell above
  } tok_t;

  // Shared control fanned out to every cell.
  typedef struct packed {
    logic              clear;
    logic              load;
    logic [SLOT_W-1:0] load_slot;
    logic [CHAR_W-1:0] load_char;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* hdl/wdu_cell.sv */
// ----------------------------------------------------------------------------
// wdu_cell
// One edit-distance cell: holds a first-word character and one column entry.
// ----------------------------------------------------------------------------
`default_nettype none

module wdu_cell import wdu_pkg::*; (
  input  logic              clk,
  input  logic [SLOT_W-1:0] slot,
  input  cell_ctrl_t        ctrl,
  input  tok_t              tok_in,
  output tok_t              tok_out,
  output logic [LEN_W-1:0]  dp_value,
  output logic [CHAR_W-1:0] chr_value
);

  logic [LEN_W-1:0] dp;
  logic [CHAR_W-1:0] chr;
  logic [LEN_W-1:0] min_ld;
  logic [LEN_W-1:0] min_all;
  logic [LEN_W-1:0] calc;

  assign min_ld  = (tok_in.left <= tok_in.diag) ? tok_in.left : tok_in.diag;
  assign min_all = (min_ld <= dp) ? min_ld : dp;
  assign calc    = (chr == tok_in.chr) ? tok_in.diag : min_all + LEN_W'(1);

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      dp            <= LEN_W'(slot) + LEN_W'(1);
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
      if (tok_in.valid) begin
        dp <= calc;
      end
    end
    // payload: hand down the new and the old value
    if (tok_in.valid) begin
      tok_out.chr  <= tok_in.chr;
      tok_out.left <= calc;
      tok_out.diag <= dp;
    end
    if (ctrl.load && (ctrl.load_slot == slot)) begin
      chr <= ctrl.load_char;
    end
  end

  assign dp_value  = dp;
  assign chr_value = chr;

endmodule

`default_nettype wire

/* hdl/word_distance_unit.sv */
// ----------------------------------------------------------------------------
// word_distance_unit
// Edit (via a cell chain), Hamming or exact-match distance between two words.
// ----------------------------------------------------------------------------
// Usage:
//   Send the first word, one character per transfer with s_tuser[2] = 0 and
//   s_tlast on its final character, then the second word with s_tuser[2] = 1.
//   On the final second-word transfer (s_tlast = 1) s_tuser[1:0] selects the
//   result: 0 edit distance, 1 Hamming distance, 2 exact match, 3 invalid.
//   One result transfer on m_tdata[5:0] (signed, -1 on bad length or kind)
//   follows each final second-word character; no other transfer gives one.
// Timing:
//   Characters are taken one per cycle while s_tready is high. The final
//   second-word character sends a wavefront down the 31-cell chain; the
//   result is loaded into the output register once the chain is empty and
//   that register is free, and s_tready stays low meanwhile.
// Stall and reset:
//   A waiting result does not block the next pair's characters; only the
//   next result waits in the drain state for the output register. rst
//   (synchronous) returns the column to 1..31 and clears all counts.
// ----------------------------------------------------------------------------
`default_nettype none

`include "word_distance_unit_assert.svh"

module word_distance_unit import wdu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] char_code
  input  logic [2:0]        s_tuser,   // [1:0] func, [2] word_sel
  input  logic              s_tlast,   // last
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata    // [5:0] dist_value, [7:6] zero
);

  localparam logic ST_LOAD  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic              state;
  logic [LEN_W-1:0]  first_len;
  logic [LEN_W-1:0]  second_len;
  logic              first_closed;
  logic [LEN_W-1:0]  mismatch_count;
  logic              words_differ;
  logic [FUNC_W-1:0] func_hold;
  logic [LEN_W-1:0]  dist_value;
  tok_t              inj;

  tok_t              tok [0:MAX_WORD];
  logic [MAX_WORD:0] tok_valid;
  logic [LEN_W-1:0]  dp_val  [0:MAX_WORD-1];
  logic [CHAR_W-1:0] chr_val [0:MAX_WORD-1];
  cell_ctrl_t        ctrl;

  logic              acc;
  logic              a_item;
  logic              b_item;
  logic              fresh;
  logic [LEN_W-1:0]  eff_len;
  logic              drain_done;
  logic              j_in;
  logic [CHAR_W-1:0] a_chr;
  logic              miss;
  logic              la_ok;
  logic              lb_ok;
  logic [SLOT_W-1:0] la_slot;
  logic [LEN_W-1:0]  result;

  assign s_tready = (state == ST_LOAD);
  assign acc      = s_tvalid & s_tready;
  assign a_item   = acc & ~s_tuser[2];
  assign b_item   = acc & s_tuser[2];

  // A first-word character after a closed word or a started second word
  // begins a new pair.
  assign fresh   = first_closed | (second_len != '0);
  assign eff_len = fresh ? '0 : first_len;

  // Wait until no token is left in the chain and the output register is free.
  assign drain_done = (state == ST_DRAIN) && !(|tok_valid) && (!m_tvalid || m_tready);

  assign ctrl.clear     = rst | drain_done | (a_item & fresh);
  assign ctrl.load      = a_item && (eff_len < LEN_W'(MAX_WORD));
  assign ctrl.load_slot = eff_len[SLOT_W-1:0];
  assign ctrl.load_char = s_tdata;

  // Hamming compare against the first-word character at the same position.
  assign j_in  = second_len < LEN_W'(MAX_WORD);
  assign a_chr = j_in ? chr_val[second_len[SLOT_W-1:0]] : '0;
  assign miss  = (second_len >= first_len) || (j_in && (a_chr != s_tdata));

  // Chain of cells; cell k holds column entry k+1.
  assign tok[0] = inj;

  genvar k;
  generate
    for (k = 0; k < MAX_WORD; k++) begin : g_cell
      wdu_cell u_cell (
        .clk       (clk),
        .slot      (SLOT_W'(k)),
        .ctrl      (ctrl),
        .tok_in    (tok[k]),
        .tok_out   (tok[k+1]),
        .dp_value  (dp_val[k]),
        .chr_value (chr_val[k])
      );
    end
    for (k = 0; k <= MAX_WORD; k++) begin : g_valid
      assign tok_valid[k] = tok[k].valid;
    end
  endgenerate

  // Result selection.
  assign la_ok   = (first_len >= LEN_W'(MIN_WORD)) && (first_len <= LEN_W'(MAX_WORD));
  assign lb_ok   = (second_len >= LEN_W'(MIN_WORD)) && (second_len <= LEN_W'(MAX_WORD));
  assign la_slot = SLOT_W'(first_len - LEN_W'(1));

  always_comb begin
    case (func_hold)
      FUNC_EDIT: begin
        result = dp_val[la_slot];
      end
      FUNC_HAMMING: begin
        result = (first_len == second_len) ? mismatch_count : DIST_INVALID;
      end
      FUNC_EXACT: begin
        result = (words_differ || (first_len != second_len)) ? LEN_W'(1) : '0;
      end
      default: begin
        result = DIST_INVALID;
      end
    endcase
    if (!la_ok || !lb_ok) begin
      result = DIST_INVALID;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_LOAD;
      first_len      <= '0;
      second_len     <= '0;
      first_closed   <= 1'b0;
      mismatch_count <= '0;
      words_differ   <= 1'b0;
      inj.valid      <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      // inject one token per second-word character
      inj.valid <= b_item;

      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (a_item) begin
        if (fresh) begin
          second_len     <= '0;
          mismatch_count <= '0;
          words_differ   <= 1'b0;
        end
        first_len    <= (eff_len < LEN_W'(MAX_WORD)) ? eff_len + LEN_W'(1)
                                                     : LEN_W'(MAX_WORD + 1);
        first_closed <= s_tlast | (~fresh & first_closed);
      end

      if (b_item) begin
        if (miss) begin
          words_differ <= 1'b1;
          if ((second_len < first_len) && (mismatch_count != '1)) begin
            mismatch_count <= mismatch_count + LEN_W'(1);
          end
        end
        second_len <= j_in ? second_len + LEN_W'(1) : LEN_W'(MAX_WORD + 1);
        if (s_tlast) begin
          state <= ST_DRAIN;
        end
      end

      // Publish the result and return to the reset state.
      if (drain_done) begin
        m_tvalid       <= 1'b1;
        first_len      <= '0;
        second_len     <= '0;
        first_closed   <= 1'b0;
        mismatch_count <= '0;
        words_differ   <= 1'b0;
        state          <= ST_LOAD;
      end
    end

    if (b_item) begin
      inj.chr  <= s_tdata;
      inj.left <= second_len + LEN_W'(1);
      inj.diag <= second_len;
      if (s_tlast) begin
        func_hold <= s_tuser[1:0];
      end
    end
    if (drain_done) begin
      dist_value <= result;
    end
  end

  assign m_tdata = {2'b00, dist_value};

  `WDU_ASSERT_SAME(a_count_bound, 1'b1, mismatch_count <= second_len)
  `WDU_ASSERT_SAME(a_count_differ, mismatch_count != '0, words_differ)
  `WDU_ASSERT_NEXT(a_drain_no_inject, state == ST_DRAIN, !tok_valid[0])
  `WDU_ASSERT_NEXT(a_publish, drain_done, m_tvalid && (state == ST_LOAD))
  `WDU_ASSERT_NEXT(a_publish_clear, drain_done, (first_len == '0) && (second_len == '0))

endmodule

`default_nettype wire

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb: word_distance_unit testbench
// Streams word pairs into the distance unit with random gaps on the input
// and random stalls on the output. A behavioral predictor computes each
// expected distance when the final second-word character is accepted, and
// the output monitor compares every result transfer against it, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb import wdu_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Codes the package does not name.
  localparam logic [FUNC_W-1:0] FUNC_BAD = 2'd3;
  localparam logic              SEL_A    = 1'b0;
  localparam logic              SEL_B    = 1'b1;

  localparam int RANDOM_ITEMS   = 750;
  localparam int RUN_ITEMS      = RANDOM_ITEMS + 24;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 2000;

  // One character transfer on the input stream.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              sel;
    logic [CHAR_W-1:0] chr;
    logic              last;
  } char_xfer_t;

  // A queued character with its pacing hints.
  typedef struct {
    char_xfer_t x;
    bit         drain;  // hold this one back until all distances are in
    bit         quiet;  // no gaps or stalls while this one is in flight
  } char_slot_t;

  logic clk;
  logic rst      = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;  // [7:0] char_code
  logic [2:0] s_tuser = '0;  // [1:0] func, [2] word_sel
  logic s_tlast  = 1'b0;     // last
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [7:0] m_tdata;       // [5:0] dist_value, [7:6] zero

  word_distance_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor state: the first word, both lengths, the Levenshtein column
  // and the running Hamming and exact-match bookkeeping.
  // --------------------------------------------------------------------------
  logic [CHAR_W-1:0] word_a_store [MAX_WORD];
  logic [LEN_W-1:0]  lev_col [MAX_WORD+1];
  logic [LEN_W-1:0]  word_a_len;
  logic [LEN_W-1:0]  word_b_len;
  logic [LEN_W-1:0]  hamming_cnt;
  logic              pair_differs;
  logic              word_a_closed;

  char_slot_t        char_backlog [$];  // characters not yet offered
  logic [LEN_W-1:0]  dist_due [$];      // distances still to come out
  logic [CHAR_W-1:0] a_spell [$];
  logic [CHAR_W-1:0] b_spell [$];

  int  mismatch_cnt = 0;
  int  gap_left     = 0;
  int  stall_left   = 0;
  bit  calm         = 1'b0;
  char_slot_t        next_slot;
  logic [LEN_W-1:0]  new_dist;
  logic [LEN_W-1:0]  old_dist;

  // The store keeps its contents: only entries below the length are read.
  function automatic void clear_distance_state();
    foreach (lev_col[i]) lev_col[i] = LEN_W'(i);
    word_a_len    = '0;
    word_b_len    = '0;
    hamming_cnt   = '0;
    pair_differs  = 1'b0;
    word_a_closed = 1'b0;
  endfunction

  // Advance the predictor by one accepted character. Returns 1 when the
  // character closes the second word, with the distance in dist_out.
  function automatic bit predict_distance(input char_xfer_t xf,
                                          output logic [LEN_W-1:0] dist_out);
    int j;
    int la;
    int lb;
    logic [LEN_W-1:0] diag;
    logic [LEN_W-1:0] up;
    logic [LEN_W-1:0] lo;
    dist_out = '0;
    if (xf.sel == SEL_A) begin
      // A first-word char after a closed word or mid second word starts over.
      if (word_a_closed || word_b_len != '0) clear_distance_state();
      if (word_a_len < MAX_WORD) begin
        word_a_store[word_a_len] = xf.chr;
        word_a_len++;
      end else begin
        word_a_len = LEN_W'(MAX_WORD + 1);
      end
      if (xf.last) word_a_closed = 1'b1;
      return 1'b0;
    end

    j  = word_b_len;
    la = word_a_len;
    if (j >= la || (j < MAX_WORD && word_a_store[j] != xf.chr)) begin
      pair_differs = 1'b1;
      if (j < la && hamming_cnt != '1) hamming_cnt++;
    end

    // Sweep one column; a saturated length on either side freezes it.
    if (j < MAX_WORD && la <= MAX_WORD) begin
      diag       = lev_col[0];
      lev_col[0] = LEN_W'(j + 1);
      for (int i = 1; i <= la; i++) begin
        up = lev_col[i];
        if (word_a_store[i-1] == xf.chr) begin
          lev_col[i] = diag;
        end else begin
          lo = lev_col[i-1];
          if (diag < lo) lo = diag;
          if (up < lo) lo = up;
          lev_col[i] = lo + 1'b1;
        end
        diag = up;
      end
    end
    word_b_len = (j < MAX_WORD) ? LEN_W'(j + 1) : LEN_W'(MAX_WORD + 1);

    if (!xf.last) return 1'b0;

    lb = word_b_len;
    if (la < MIN_WORD || la > MAX_WORD || lb < MIN_WORD || lb > MAX_WORD) begin
      dist_out = DIST_INVALID;
    end else begin
      case (xf.func)
        FUNC_EDIT:    dist_out = lev_col[la];
        FUNC_HAMMING: dist_out = (la == lb) ? hamming_cnt : DIST_INVALID;
        FUNC_EXACT:   dist_out = (pair_differs || la != lb) ? LEN_W'(1) : LEN_W'(0);
        default:      dist_out = DIST_INVALID;
      endcase
    end
    clear_distance_state();
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus building
  // --------------------------------------------------------------------------
  function automatic logic [CHAR_W-1:0] rand_char(input int base, input int span);
    return CHAR_W'(base + $urandom_range(0, span - 1));
  endfunction

  // Mostly short words; now and then too short, exactly maximal or overlong.
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom_range(0, MIN_WORD - 1);
    if (r == 1) return $urandom_range(MAX_WORD + 1, MAX_WORD + 4);
    if (r == 2) return MAX_WORD;
    return $urandom_range(MIN_WORD, 10);
  endfunction

  // Queue the characters of a_spell or b_spell. func only matters on the
  // closing second-word char; elsewhere it is random noise.
  task automatic queue_word(input logic sel, input logic [FUNC_W-1:0] fn_final,
                            input bit close, input bit drain_first);
    int n;
    char_slot_t s;
    n = (sel == SEL_A) ? a_spell.size() : b_spell.size();
    for (int k = 0; k < n; k++) begin
      s.x.sel  = sel;
      s.x.chr  = (sel == SEL_A) ? a_spell[k] : b_spell[k];
      s.x.last = close && (k == n - 1);
      s.x.func = (s.x.last && sel == SEL_B) ? fn_final : FUNC_W'($urandom_range(0, 3));
      s.drain  = drain_first && (k == 0);
      s.quiet  = (char_backlog.size() >= RUN_ITEMS - 150) ||
                 (char_backlog.size() >= 350 && char_backlog.size() < 430);
      char_backlog.push_back(s);
    end
  endtask

  task automatic queue_random_pair(input bit drain_first);
    int span;
    int base;
    int n;
    int r;
    logic [FUNC_W-1:0] fn;

    // Junk that the pair must wipe out: a closed first word, maybe followed
    // by an unfinished second word.
    r = $urandom_range(0, 7);
    if (r <= 1) begin
      a_spell.delete();
      b_spell.delete();
      n = $urandom_range(1, 6);
      for (int k = 0; k < n; k++) a_spell.push_back(rand_char(1, 255));
      queue_word(SEL_A, FUNC_EDIT, 1'b1, 1'b0);
      if (r == 1) begin
        n = $urandom_range(1, 3);
        for (int k = 0; k < n; k++) b_spell.push_back(rand_char(1, 255));
        queue_word(SEL_B, FUNC_EDIT, 1'b0, 1'b0);
      end
    end

    // A narrow alphabet makes matches likely and the distances interesting.
    span = ($urandom_range(0, 2) == 0) ? 255 : $urandom_range(2, 4);
    base = $urandom_range(1, 256 - span);
    a_spell.delete();
    b_spell.delete();
    n = pick_len();
    for (int k = 0; k < n; k++) a_spell.push_back(rand_char(base, span));

    case ($urandom_range(0, 3))
      0: begin
        n = pick_len();
        for (int k = 0; k < n; k++) b_spell.push_back(rand_char(base, span));
      end
      1: begin
        foreach (a_spell[k]) begin
          if ($urandom_range(0, 3) == 0) b_spell.push_back(rand_char(base, span));
          else b_spell.push_back(a_spell[k]);
        end
      end
      2: begin
        foreach (a_spell[k]) begin
          r = $urandom_range(0, 9);
          if (r == 1) begin
            b_spell.push_back(rand_char(base, span));
          end else if (r == 2) begin
            b_spell.push_back(rand_char(base, span));
            b_spell.push_back(a_spell[k]);
          end else if (r != 0) begin
            b_spell.push_back(a_spell[k]);
          end
        end
      end
      default: b_spell = a_spell;
    endcase
    if (b_spell.size() == 0) b_spell.push_back(rand_char(base, span));

    r = $urandom_range(0, 9);
    fn = (r < 3) ? FUNC_EDIT : (r < 6) ? FUNC_HAMMING : (r < 9) ? FUNC_EXACT : FUNC_BAD;

    // Once in a while leave the first word without its last mark.
    queue_word(SEL_A, FUNC_EDIT, $urandom_range(0, 9) != 0, drain_first);
    queue_word(SEL_B, fn, 1'b1, 1'b0);
  endtask

  // --------------------------------------------------------------------------
  // Input driver: offer queued characters, predict on every transfer.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        if (predict_distance({s_tuser[1:0], s_tuser[2], s_tdata, s_tlast}, new_dist))
          dist_due.push_back(new_dist);
      end
      // Only touch the bus once the current transfer has gone through.
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (char_backlog.size() == 0) begin
          s_tvalid <= 1'b0;
        end else if (char_backlog[0].drain &&
                     (dist_due.size() != 0 || (m_tvalid && m_tready))) begin
          // Hold until every outstanding distance has been taken.
          s_tvalid <= 1'b0;
        end else if (!char_backlog[0].quiet && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(0, 4);
          s_tvalid <= 1'b0;
        end else begin
          next_slot = char_backlog.pop_front();
          s_tvalid  <= 1'b1;
          s_tdata   <= next_slot.x.chr;
          s_tuser   <= {next_slot.x.sel, next_slot.x.func};
          s_tlast   <= next_slot.x.last;
          calm      <= next_slot.quiet;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor: stall at random, check each result transfer in order.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [LEN_W-1:0] want);
    mismatch_cnt++;
    $display("%0t ERROR %s: got %0d (0x%02h), expected %0d", $time, what,
             $signed(got[LEN_W-1:0]), got, $signed(want));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (dist_due.size() == 0) begin
          report_mismatch("result with nothing expected", m_tdata, '0);
        end else begin
          old_dist = dist_due.pop_front();
          if (m_tdata !== {2'b00, old_dist})
            report_mismatch("dist_value", m_tdata, old_dist);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(0, 4);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // End the run if nothing moves on either side for too long.
  initial begin
    int idle_run;
    idle_run = 0;
    while (idle_run < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_run = 0;
      else idle_run++;
    end
    $display("ERROR: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int pair_no;
    clear_distance_state();

    // Identical words at the byte extremes: exact match.
    a_spell = '{8'h01, 8'hFF, 8'h80, 8'h7F};
    b_spell = a_spell;
    queue_word(SEL_A, FUNC_EDIT, 1'b1, 1'b0);
    queue_word(SEL_B, FUNC_EXACT, 1'b1, 1'b0);
    // Second word against an empty first word.
    a_spell.delete();
    b_spell = '{8'h10, 8'h20, 8'h30, 8'h40};
    queue_word(SEL_B, FUNC_EDIT, 1'b1, 1'b0);
    // A closed first word replaced by a new one, then a Hamming count.
    a_spell = '{8'h41, 8'h42, 8'h43, 8'h44};
    queue_word(SEL_A, FUNC_EDIT, 1'b1, 1'b0);
    a_spell = '{8'h41, 8'h42, 8'h43, 8'h45};
    queue_word(SEL_A, FUNC_EDIT, 1'b1, 1'b0);
    b_spell = '{8'h41, 8'h43, 8'h43, 8'h46};
    queue_word(SEL_B, FUNC_HAMMING, 1'b1, 1'b0);

    pair_no = 0;
    while (char_backlog.size() < RUN_ITEMS) begin
      queue_random_pair(pair_no % 12 == 0);
      pair_no++;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (char_backlog.size() != 0 || s_tvalid || dist_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
+incdir+hdl
hdl/wdu_pkg.sv
hdl/wdu_cell.sv
hdl/word_distance_unit.sv
dv/tb.sv
